@@ design/rtnh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_pkg: shared constants for the ray / triangle nearest hit block
// Widths of the internal math, distance encoding and register indexes.
// ----------------------------------------------------------------------------
package rtnh_pkg;

	localparam int WIDE          = 128;
	localparam int DIST_BITS     = 48;
	localparam int DEF_COORD_BITS = 32;
	localparam int DEF_FRAC_BITS  = 8;
	localparam int NUM_REGS      = 7;

	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	localparam logic [2:0] REG_ORG_X = 3'd0;
	localparam logic [2:0] REG_ORG_Y = 3'd1;
	localparam logic [2:0] REG_ORG_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X = 3'd3;
	localparam logic [2:0] REG_DIR_Y = 3'd4;
	localparam logic [2:0] REG_DIR_Z = 3'd5;
	localparam logic [2:0] REG_CEIL  = 3'd6;

endpackage

@@ design/rtnh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_front: triangle intake and request queue
// Accepts triangles, drops those that neither test nor close a scene, and
// holds the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rtnh_front #(
	parameter int COORD_BITS = rtnh_pkg::DEF_COORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [9*COORD_BITS-1:0]   s_vert,
	input  logic                      s_ground,
	input  logic                      s_last,
	output logic                      q_valid,
	output logic [9*COORD_BITS+1:0]   q_data,
	input  logic                      q_pop
);

	localparam int EW = 9*COORD_BITS + 2;

	logic [EW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid & s_tready & (s_ground | s_last);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= {s_last, s_ground, s_vert};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule

@@ design/rtnh_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_mul: bit-serial signed multiplier
// Wide signed operand times narrow signed operand, one narrow bit a cycle,
// product modulo 2^WIDE.
// ----------------------------------------------------------------------------
module rtnh_mul #(
	parameter int NB = rtnh_pkg::DEF_COORD_BITS + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [rtnh_pkg::WIDE-1:0] a,
	input  logic signed [NB-1:0]             b,
	output logic                             done,
	output logic signed [rtnh_pkg::WIDE-1:0] prod
);

	localparam int W  = rtnh_pkg::WIDE;
	localparam int CW = $clog2(NB);

	logic signed [W-1:0] acc_q;
	logic        [W-1:0] a_q;
	logic       [NB-1:0] b_q;
	logic       [CW-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic        [W-1:0] term;
	logic                top_bit;

	assign term    = b_q[0] ? a_q : '0;
	assign top_bit = (cnt_q == CW'(NB-1));
	assign done    = done_q;
	assign prod    = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= top_bit ? acc_q - $signed(term) : acc_q + $signed(term);
			a_q   <= a_q << 1;
			b_q   <= b_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (top_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ design/rtnh_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_div: restoring divider with saturated quotient
// Unsigned WIDE-bit division, one quotient bit a cycle; the quotient clamps
// to all ones once it passes the distance range.
// ----------------------------------------------------------------------------
module rtnh_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rtnh_pkg::WIDE-1:0]           num,
	input  logic [rtnh_pkg::WIDE-1:0]           den,
	output logic                                done,
	output logic [rtnh_pkg::DIST_BITS-1:0]      quo
);

	localparam int W  = rtnh_pkg::WIDE;
	localparam int DB = rtnh_pkg::DIST_BITS;
	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  num_q;
	logic [W-1:0]  den_q;
	logic [DB:0]   q_q;
	logic          sat_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  r;
	logic          ge;
	logic [DB:0]   qn;

	assign r    = {rem_q[W-2:0], num_q[W-1]};
	assign ge   = (r >= den_q);
	assign qn   = {q_q[DB-1:0], ge};
	assign done = done_q;
	assign quo  = sat_q ? rtnh_pkg::DIST_MAX : q_q[DB-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r - den_q : r;
			num_q <= num_q << 1;
			if (!sat_q) begin
				q_q <= qn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sat_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (!sat_q && (qn > {1'b0, rtnh_pkg::DIST_MAX})) begin
					sat_q <= 1'b1;
				end
				if (cnt_q == CW'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ design/rtnh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_back: intersection sequencer and nearest hit tracking
// Runs the cross and dot products through the shared serial multiplier,
// tests the hit, divides for distance, keeps the minimum, emits the point.
// ----------------------------------------------------------------------------
module rtnh_back #(
	parameter int COORD_BITS = rtnh_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = rtnh_pkg::DEF_FRAC_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_valid,
	input  logic [9*COORD_BITS+1:0]                 q_data,
	output logic                                    q_pop,
	input  logic [rtnh_pkg::NUM_REGS*COORD_BITS-1:0] cfg,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    out_found,
	output logic [COORD_BITS-1:0]                   out_x,
	output logic [COORD_BITS-1:0]                   out_y,
	output logic [COORD_BITS-1:0]                   out_z
);

	localparam int CB = COORD_BITS;
	localparam int NB = CB + 1;
	localparam int W  = rtnh_pkg::WIDE;
	localparam int DB = rtnh_pkg::DIST_BITS;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOAD   = 4'd1;
	localparam logic [3:0] ST_MSTART = 4'd2;
	localparam logic [3:0] ST_MWAIT  = 4'd3;
	localparam logic [3:0] ST_ACC    = 4'd4;
	localparam logic [3:0] ST_SIGN   = 4'd5;
	localparam logic [3:0] ST_TEST   = 4'd6;
	localparam logic [3:0] ST_DSTART = 4'd7;
	localparam logic [3:0] ST_DWAIT  = 4'd8;
	localparam logic [3:0] ST_HSTART = 4'd9;
	localparam logic [3:0] ST_HWAIT  = 4'd10;
	localparam logic [3:0] ST_ESTART = 4'd11;
	localparam logic [3:0] ST_EWAIT  = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;

	localparam logic [3:0] WS_DIR0 = 4'd0;
	localparam logic [3:0] WS_DIR1 = 4'd1;
	localparam logic [3:0] WS_DIR2 = 4'd2;
	localparam logic [3:0] WS_S0   = 4'd3;
	localparam logic [3:0] WS_S1   = 4'd4;
	localparam logic [3:0] WS_S2   = 4'd5;
	localparam logic [3:0] WS_P0   = 4'd6;
	localparam logic [3:0] WS_P1   = 4'd7;
	localparam logic [3:0] WS_P2   = 4'd8;
	localparam logic [3:0] WS_Q0   = 4'd9;
	localparam logic [3:0] WS_Q1   = 4'd10;
	localparam logic [3:0] WS_Q2   = 4'd11;

	localparam logic [3:0] NS_E0   = 4'd0;
	localparam logic [3:0] NS_E1   = 4'd1;
	localparam logic [3:0] NS_E2   = 4'd2;
	localparam logic [3:0] NS_F0   = 4'd3;
	localparam logic [3:0] NS_F1   = 4'd4;
	localparam logic [3:0] NS_F2   = 4'd5;
	localparam logic [3:0] NS_S0   = 4'd6;
	localparam logic [3:0] NS_S1   = 4'd7;
	localparam logic [3:0] NS_S2   = 4'd8;
	localparam logic [3:0] NS_DIR0 = 4'd9;
	localparam logic [3:0] NS_DIR1 = 4'd10;
	localparam logic [3:0] NS_DIR2 = 4'd11;

	localparam logic [3:0] D_NONE = 4'd0;
	localparam logic [3:0] D_P0   = 4'd1;
	localparam logic [3:0] D_P1   = 4'd2;
	localparam logic [3:0] D_P2   = 4'd3;
	localparam logic [3:0] D_DET  = 4'd4;
	localparam logic [3:0] D_Q0   = 4'd5;
	localparam logic [3:0] D_Q1   = 4'd6;
	localparam logic [3:0] D_Q2   = 4'd7;
	localparam logic [3:0] D_UN   = 4'd8;
	localparam logic [3:0] D_VN   = 4'd9;
	localparam logic [3:0] D_TN   = 4'd10;

	localparam logic [4:0] STEP_LAST = 5'd23;

	localparam logic signed [W-1:0] SAT_HI = (W'(1) << (CB-1)) - W'(1);
	localparam logic signed [W-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [3:0] wsel;
		logic [3:0] nsel;
		logic       sub;
		logic [3:0] dest;
	} step_t;

	function automatic step_t step_info(input logic [4:0] st);
		step_t r;
		r = '{WS_DIR0, NS_E0, 1'b0, D_NONE};
		case (st)
			5'd0:  r = '{WS_DIR1, NS_F2, 1'b0, D_NONE};
			5'd1:  r = '{WS_DIR2, NS_F1, 1'b1, D_P0};
			5'd2:  r = '{WS_DIR2, NS_F0, 1'b0, D_NONE};
			5'd3:  r = '{WS_DIR0, NS_F2, 1'b1, D_P1};
			5'd4:  r = '{WS_DIR0, NS_F1, 1'b0, D_NONE};
			5'd5:  r = '{WS_DIR1, NS_F0, 1'b1, D_P2};
			5'd6:  r = '{WS_P0, NS_E0, 1'b0, D_NONE};
			5'd7:  r = '{WS_P1, NS_E1, 1'b0, D_NONE};
			5'd8:  r = '{WS_P2, NS_E2, 1'b0, D_DET};
			5'd9:  r = '{WS_S1, NS_E2, 1'b0, D_NONE};
			5'd10: r = '{WS_S2, NS_E1, 1'b1, D_Q0};
			5'd11: r = '{WS_S2, NS_E0, 1'b0, D_NONE};
			5'd12: r = '{WS_S0, NS_E2, 1'b1, D_Q1};
			5'd13: r = '{WS_S0, NS_E1, 1'b0, D_NONE};
			5'd14: r = '{WS_S1, NS_E0, 1'b1, D_Q2};
			5'd15: r = '{WS_P0, NS_S0, 1'b0, D_NONE};
			5'd16: r = '{WS_P1, NS_S1, 1'b0, D_NONE};
			5'd17: r = '{WS_P2, NS_S2, 1'b0, D_UN};
			5'd18: r = '{WS_Q0, NS_DIR0, 1'b0, D_NONE};
			5'd19: r = '{WS_Q1, NS_DIR1, 1'b0, D_NONE};
			5'd20: r = '{WS_Q2, NS_DIR2, 1'b0, D_VN};
			5'd21: r = '{WS_Q0, NS_F0, 1'b0, D_NONE};
			5'd22: r = '{WS_Q1, NS_F1, 1'b0, D_NONE};
			5'd23: r = '{WS_Q2, NS_F2, 1'b0, D_TN};
			default: r = '{WS_DIR0, NS_E0, 1'b0, D_NONE};
		endcase
		return r;
	endfunction

	logic [3:0]           state_q;
	logic [4:0]           step_q;
	logic [1:0]           k_q;
	logic                 last_q;
	logic                 have_q;
	logic [DB-1:0]        near_q;
	logic [DB-1:0]        dist_q;
	logic signed [NB-1:0] e_q [3];
	logic signed [NB-1:0] f_q [3];
	logic signed [NB-1:0] s_q [3];
	logic signed [W-1:0]  p_q [3];
	logic signed [W-1:0]  qv_q [3];
	logic signed [W-1:0]  det_q;
	logic signed [W-1:0]  un_q;
	logic signed [W-1:0]  vn_q;
	logic signed [W-1:0]  tn_q;
	logic signed [W-1:0]  acc_q;
	logic [CB-1:0]        c_q [3];
	logic                 out_valid_q;
	logic                 out_found_q;
	logic [CB-1:0]        out_x_q;
	logic [CB-1:0]        out_y_q;
	logic [CB-1:0]        out_z_q;

	logic [CB-1:0]        org [3];
	logic [CB-1:0]        dir [3];
	logic [CB-1:0]        ceil_h;
	logic [CB-1:0]        vtx [9];
	step_t                si;
	logic                 mul_start;
	logic signed [W-1:0]  mul_a;
	logic signed [NB-1:0] mul_b;
	logic                 mul_done;
	logic signed [W-1:0]  mul_prod;
	logic                 div_done;
	logic [DB-1:0]        div_quo;
	logic signed [W-1:0]  acc_next;
	logic signed [W-1:0]  uv;
	logic                 test_fail;
	logic [1:0]           csel;
	logic signed [W-1:0]  coord;
	logic signed [W-1:0]  coord_sat;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			org[k] = cfg[(int'(rtnh_pkg::REG_ORG_X) + k)*CB +: CB];
			dir[k] = cfg[(int'(rtnh_pkg::REG_DIR_X) + k)*CB +: CB];
		end
		for (int j = 0; j < 9; j++) begin
			vtx[j] = q_data[j*CB +: CB];
		end
	end
	assign ceil_h = cfg[int'(rtnh_pkg::REG_CEIL)*CB +: CB];

	assign si = step_info(step_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MSTART) begin
			case (si.wsel)
				WS_DIR0: mul_a = W'($signed(dir[0]));
				WS_DIR1: mul_a = W'($signed(dir[1]));
				WS_DIR2: mul_a = W'($signed(dir[2]));
				WS_S0:   mul_a = W'(s_q[0]);
				WS_S1:   mul_a = W'(s_q[1]);
				WS_S2:   mul_a = W'(s_q[2]);
				WS_P0:   mul_a = p_q[0];
				WS_P1:   mul_a = p_q[1];
				WS_P2:   mul_a = p_q[2];
				WS_Q0:   mul_a = qv_q[0];
				WS_Q1:   mul_a = qv_q[1];
				WS_Q2:   mul_a = qv_q[2];
				default: mul_a = '0;
			endcase
			case (si.nsel)
				NS_E0:   mul_b = e_q[0];
				NS_E1:   mul_b = e_q[1];
				NS_E2:   mul_b = e_q[2];
				NS_F0:   mul_b = f_q[0];
				NS_F1:   mul_b = f_q[1];
				NS_F2:   mul_b = f_q[2];
				NS_S0:   mul_b = s_q[0];
				NS_S1:   mul_b = s_q[1];
				NS_S2:   mul_b = s_q[2];
				NS_DIR0: mul_b = NB'($signed(dir[0]));
				NS_DIR1: mul_b = NB'($signed(dir[1]));
				NS_DIR2: mul_b = NB'($signed(dir[2]));
				default: mul_b = '0;
			endcase
		end else if (state_q == ST_HSTART) begin
			mul_a = $signed(W'(dist_q));
			mul_b = NB'($signed(dir[1]));
		end else begin
			mul_a = $signed(W'(near_q));
			mul_b = NB'($signed(dir[k_q]));
		end
	end

	assign mul_start = (state_q == ST_MSTART) || (state_q == ST_HSTART) ||
	                   ((state_q == ST_ESTART) && have_q);

	rtnh_mul #(.NB(NB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	rtnh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DSTART),
		.num    (tn_q << FRAC_BITS),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign acc_next  = si.sub ? acc_q - mul_prod : acc_q + mul_prod;
	assign uv        = un_q + vn_q;
	assign test_fail = un_q[W-1] || (det_q < un_q) || vn_q[W-1] || (det_q < uv) ||
	                   tn_q[W-1];
	assign csel      = (state_q == ST_HWAIT) ? 2'd1 : k_q;
	assign coord     = W'($signed(org[csel])) + (mul_prod >>> FRAC_BITS);
	assign coord_sat = (coord > SAT_HI) ? SAT_HI : ((coord < SAT_LO) ? SAT_LO : coord);

	assign q_pop     = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					e_q[k] <= NB'($signed(vtx[3+k])) - NB'($signed(vtx[k]));
					f_q[k] <= NB'($signed(vtx[6+k])) - NB'($signed(vtx[k]));
					s_q[k] <= NB'($signed(org[k])) - NB'($signed(vtx[k]));
				end
				acc_q <= '0;
			end
			ST_ACC: begin
				if (si.dest == D_NONE) begin
					acc_q <= acc_next;
				end else begin
					acc_q <= '0;
				end
				case (si.dest)
					D_P0:    p_q[0]  <= acc_next;
					D_P1:    p_q[1]  <= acc_next;
					D_P2:    p_q[2]  <= acc_next;
					D_DET:   det_q   <= acc_next;
					D_Q0:    qv_q[0] <= acc_next;
					D_Q1:    qv_q[1] <= acc_next;
					D_Q2:    qv_q[2] <= acc_next;
					D_UN:    un_q    <= acc_next;
					D_VN:    vn_q    <= acc_next;
					D_TN:    tn_q    <= acc_next;
					default: ;
				endcase
			end
			ST_SIGN: begin
				if (det_q[W-1]) begin
					det_q <= -det_q;
					un_q  <= -un_q;
					vn_q  <= -vn_q;
					tn_q  <= -tn_q;
				end
			end
			ST_DWAIT: begin
				if (div_done) begin
					dist_q <= div_quo;
				end
			end
			ST_EWAIT: begin
				if (mul_done) begin
					c_q[k_q] <= coord_sat[CB-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			k_q         <= '0;
			last_q      <= 1'b0;
			have_q      <= 1'b0;
			near_q      <= rtnh_pkg::DIST_MAX;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_z_q     <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					last_q <= q_data[9*CB+1];
					step_q <= '0;
					k_q    <= '0;
					if (q_data[9*CB]) begin
						state_q <= ST_MSTART;
					end else begin
						state_q <= ST_ESTART;
					end
				end
				ST_MSTART: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					step_q <= step_q + 5'd1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_MSTART;
					end
				end
				ST_SIGN: begin
					if (det_q == '0) begin
						state_q <= last_q ? ST_ESTART : ST_IDLE;
					end else begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (test_fail) begin
						state_q <= last_q ? ST_ESTART : ST_IDLE;
					end else begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						if (div_quo >= near_q) begin
							state_q <= last_q ? ST_ESTART : ST_IDLE;
						end else begin
							state_q <= ST_HSTART;
						end
					end
				end
				ST_HSTART: state_q <= ST_HWAIT;
				ST_HWAIT: begin
					if (mul_done) begin
						if (!(W'($signed(ceil_h)) < coord)) begin
							near_q <= dist_q;
							have_q <= 1'b1;
						end
						state_q <= last_q ? ST_ESTART : ST_IDLE;
					end
				end
				ST_ESTART: begin
					state_q <= have_q ? ST_EWAIT : ST_OUT;
				end
				ST_EWAIT: begin
					if (mul_done) begin
						if (k_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_ESTART;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= have_q;
						out_x_q     <= have_q ? c_q[0] : '0;
						out_y_q     <= have_q ? c_q[1] : '0;
						out_z_q     <= have_q ? c_q[2] : '0;
						have_q      <= 1'b0;
						near_q      <= rtnh_pkg::DIST_MAX;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/ray_triangle_nearest_hit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_top: nearest ground hit of a picking ray
// Triangles stream in on the s_axis channel (tuser = ground flag, tlast =
// last triangle of the scene). Ray origin, direction and ceiling sit in APB
// registers at byte offsets 0x00..0x18 (stride 8 up to 0x30 when COORD_BITS > 32).
// Each tlast request yields one m_axis request: tuser = hit found, tdata =
// hit x, y, z (zero when nothing was hit).
// A two-entry queue decouples intake from the math; s_axis_tready drops only
// when it is full. Non-ground, non-last triangles are dropped at intake.
// A ground triangle that passes all tests takes 24 serial products, a divide
// and a height check; a dropped triangle ends at intake. A result adds a
// serial product per hit coordinate when a hit is held. The shared
// bit-serial multiplier and the bit-serial divider do this work.
// While m_axis is stalled the block keeps taking and testing triangles; a
// further result waits until the output register empties.
// Reset clears the registers to origin 0, direction 0, ceiling at maximum,
// and empties the queue and the running minimum.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_top #(
	parameter int COORD_BITS = rtnh_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = rtnh_pkg::DEF_FRAC_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        psel,
	input  logic                                        penable,
	input  logic                                        pwrite,
	input  logic [((COORD_BITS > 32) ? 6 : 5)-1:0]      paddr,
	input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0]    pwdata,
	output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]    prdata,
	output logic                                        pready,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z, zero fill
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
	// is_ground
	input  logic                                        s_axis_tuser,
	input  logic                                        s_axis_tlast,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// hit_x, hit_y, hit_z, zero fill
	output logic [((3*COORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
	// hit_found
	output logic                                        m_axis_tuser
);

	localparam int CB   = COORD_BITS;
	localparam int DW   = (CB > 32) ? 64 : 32;
	localparam int AW   = (CB > 32) ? 6 : 5;
	localparam int OTDW = ((3*CB+7)/8)*8;
	localparam int NR   = rtnh_pkg::NUM_REGS;

	logic [CB-1:0]        cfg_q [NR];
	logic [NR*CB-1:0]     cfg_flat;
	logic [2:0]           idx;
	logic                 wr_en;
	logic                 q_valid;
	logic [9*CB+1:0]      q_data;
	logic                 q_pop;
	logic [CB-1:0]        hx;
	logic [CB-1:0]        hy;
	logic [CB-1:0]        hz;

	assign pready = 1'b1;
	assign idx    = paddr[AW-1:AW-3];
	assign wr_en  = psel & penable & pwrite & pready;

	always_comb begin
		for (int i = 0; i < NR; i++) begin
			cfg_flat[i*CB +: CB] = cfg_q[i];
		end
		prdata = '0;
		if (idx < 3'(NR)) begin
			prdata = DW'(cfg_q[idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NR; i++) begin
				cfg_q[i] <= '0;
			end
			cfg_q[rtnh_pkg::REG_CEIL] <= {1'b0, {(CB-1){1'b1}}};
		end else if (wr_en && (idx < 3'(NR))) begin
			cfg_q[idx] <= pwdata[CB-1:0];
		end
	end

	rtnh_front #(.COORD_BITS(CB)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_vert   (s_axis_tdata[9*CB-1:0]),
		.s_ground (s_axis_tuser),
		.s_last   (s_axis_tlast),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	rtnh_back #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.cfg       (cfg_flat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (m_axis_tuser),
		.out_x     (hx),
		.out_y     (hy),
		.out_z     (hz)
	);

	assign m_axis_tdata = OTDW'({hz, hy, hx});

endmodule
